### src/gcb_pkg.sv
// ============================================================================
// gcb_pkg - shared constants, types and table builder for the colour blender
// Holds the default fixed-point widths, the stream packing widths and the
// elaboration-time builder of the sRGB-to-linear decode table.
// ============================================================================
package gcb_pkg;

   // default fixed-point formats
   localparam int LINEAR_FRAC_BITS_DEF = 16;
   localparam int WEIGHT_FRAC_BITS_DEF = 16;

   // colour code and table geometry
   localparam int CODE_W    = 8;
   localparam int NUM_CODES = 256;
   localparam int NUM_CHAN  = 3;
   localparam int DEC_W     = 32;

   // stream packing
   localparam int COLOR_W     = 32;
   localparam int WEIGHT_W    = 17;
   localparam int REQ_FIELD_W = 2 * COLOR_W + WEIGHT_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = COLOR_W;

   typedef logic [DEC_W-1:0] dec_table_type [NUM_CODES];

   // x^5 in Q0.30, truncating after each product
   function automatic longint unsigned pow5_q30(longint unsigned r);
      longint unsigned t;
      t = r;
      for (int i = 0; i < 4; i++) begin
         t = (t * r) >> 30;
      end
      return t;
   endfunction

   // linear light of one sRGB code in Q0.lin_bits
   function automatic longint unsigned decode_code(longint unsigned c, int lin_bits);
      longint unsigned q;
      longint unsigned s;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned v;
      if (c <= 64'd10) begin
         return ((c * 64'd100 << lin_bits) + 64'd164730) / 64'd329460;
      end
      q  = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
      s  = (q * q) >> 30;
      lo = 64'd0;
      hi = 64'd1 << 30;
      // fifth root of x^2 by bisection gives x^0.4
      while (lo < hi) begin
         mid = (lo + hi + 64'd1) >> 1;
         if (pow5_q30(mid) <= s) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      v = (s * lo) >> 30;
      return (v + (64'd1 << (29 - lin_bits))) >> (30 - lin_bits);
   endfunction

   // full decode table, built at elaboration
   function automatic dec_table_type build_dec_table(int lin_bits);
      dec_table_type tbl;
      for (int c = 0; c < NUM_CODES; c++) begin
         tbl[c] = DEC_W'(decode_code(longint'(c), lin_bits));
      end
      return tbl;
   endfunction

endpackage

### src/gamma_correct_color_blend_top.sv
// ============================================================================
// gamma_correct_color_blend_top - gamma-correct RGBA blend, fully pipelined
// Decodes sRGB to linear, interpolates, re-encodes by successive approximation.
// ============================================================================
// Usage:
//   req_* carries one beat per pixel: two packed RGBA colours (red in the top
//   byte) and a Q0.WEIGHT_FRAC_BITS blend weight; weights above one saturate.
//   rsp_* returns one blended RGBA colour per request beat, in order.
// Pipeline: one decode-table stage, one multiply stage, one sum stage, and eight
//   encode stages, each settling one bit of the output code with a lookup into
//   the decode table.
// Throughput: one beat per cycle with no stall. Each stage carries its own
//   valid bit and takes new data whenever it is empty or the next stage moves,
//   so bubbles close up and req_tready stays high while any stage has room.
// Reset: clears all stage valid bits; the pipeline comes out empty and ready.
// Stall: with rsp_tready low, the output beat holds and stages fill behind it;
//   req_tready drops only once every stage holds a beat. Nothing is dropped.
// ============================================================================
module gamma_correct_color_blend_top #(
   parameter int LINEAR_FRAC_BITS = gcb_pkg::LINEAR_FRAC_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = gcb_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: first_color[31:0], second_color[63:32], blend_weight[80:64], zero pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [gcb_pkg::REQ_TDATA_W-1:0] req_tdata,
   // response: blended_color[31:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [gcb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import gcb_pkg::*;

   localparam int LIN_W      = LINEAR_FRAC_BITS + 1;
   localparam int WGT_W      = WEIGHT_FRAC_BITS + 1;
   localparam int CMP_W      = (WGT_W > WEIGHT_W) ? WGT_W : WEIGHT_W;
   localparam int PROD_W     = LIN_W + WGT_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int APROD_W    = CODE_W + WGT_W;
   localparam int ASUM_W     = APROD_W + 1;
   localparam int ENC_STAGES = CODE_W;
   localparam int ENC_FIRST  = 3;
   localparam int NUM_STAGES = ENC_FIRST + ENC_STAGES;
   localparam logic [WGT_W-1:0] WeightFull = WGT_W'(1) << WEIGHT_FRAC_BITS;
   localparam dec_table_type DecTable = build_dec_table(LINEAR_FRAC_BITS);

   // stage control
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] advance;

   // request fields
   logic [COLOR_W-1:0]  first_color;
   logic [COLOR_W-1:0]  second_color;
   logic [WEIGHT_W-1:0] blend_weight;
   logic [WGT_W-1:0]    weight_sat;

   // stage 0: decoded channels
   logic [LIN_W-1:0]  lin1_ff  [NUM_CHAN];
   logic [LIN_W-1:0]  lin2_ff  [NUM_CHAN];
   logic [WGT_W-1:0]  weight_ff;
   logic [CODE_W-1:0] alpha1_ff;
   logic [CODE_W-1:0] alpha2_ff;

   // stage 1: products
   logic [PROD_W-1:0]  prod1_ff [NUM_CHAN];
   logic [PROD_W-1:0]  prod2_ff [NUM_CHAN];
   logic [APROD_W-1:0] aprod1_ff;
   logic [APROD_W-1:0] aprod2_ff;

   // stage 2: interpolated values
   logic [LIN_W-1:0]  mix_ff [NUM_CHAN];
   logic [CODE_W-1:0] amix_ff;
   logic [SUM_W-1:0]  mix_sum [NUM_CHAN];
   logic [ASUM_W-1:0] amix_sum;

   // encode stages
   logic [CODE_W-1:0] code_ff  [ENC_STAGES][NUM_CHAN];
   logic [CODE_W-1:0] code_in  [ENC_STAGES][NUM_CHAN];
   logic [LIN_W-1:0]  vlin_ff  [ENC_STAGES][NUM_CHAN];
   logic [CODE_W-1:0] alpha_ff [ENC_STAGES];

   assign first_color  = req_tdata[COLOR_W-1:0];
   assign second_color = req_tdata[2*COLOR_W-1:COLOR_W];
   assign blend_weight = req_tdata[REQ_FIELD_W-1:2*COLOR_W];

   // ready ripples back: a stage moves when empty or when its successor moves
   always_comb begin
      advance[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
      valid_in[0] = req_tvalid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (advance[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_tready = advance[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

   // weight above one saturates
   always_comb begin
      if (CMP_W'(blend_weight) > CMP_W'(WeightFull)) begin
         weight_sat = WeightFull;
      end else begin
         weight_sat = WGT_W'(blend_weight);
      end
   end

   // stage 0: table decode of R, G, B (red is the top byte)
   always_ff @(posedge clock) begin
      if (advance[0]) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            lin1_ff[ch] <= DecTable[first_color[COLOR_W-1-CODE_W*ch -: CODE_W]][LIN_W-1:0];
            lin2_ff[ch] <= DecTable[second_color[COLOR_W-1-CODE_W*ch -: CODE_W]][LIN_W-1:0];
         end
         weight_ff <= weight_sat;
         alpha1_ff <= first_color[CODE_W-1:0];
         alpha2_ff <= second_color[CODE_W-1:0];
      end
   end

   // stage 1: weighted products
   always_ff @(posedge clock) begin
      if (advance[1]) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            prod1_ff[ch] <= PROD_W'(lin1_ff[ch]) * PROD_W'(WeightFull - weight_ff);
            prod2_ff[ch] <= PROD_W'(lin2_ff[ch]) * PROD_W'(weight_ff);
         end
         aprod1_ff <= APROD_W'(alpha1_ff) * APROD_W'(WeightFull - weight_ff);
         aprod2_ff <= APROD_W'(alpha2_ff) * APROD_W'(weight_ff);
      end
   end

   // stage 2: sum and drop the weight fraction
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         mix_sum[ch] = SUM_W'(prod1_ff[ch]) + SUM_W'(prod2_ff[ch]);
      end
      amix_sum = ASUM_W'(aprod1_ff) + ASUM_W'(aprod2_ff);
   end

   always_ff @(posedge clock) begin
      if (advance[2]) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            mix_ff[ch] <= LIN_W'(mix_sum[ch] >> WEIGHT_FRAC_BITS);
         end
         amix_ff <= CODE_W'(amix_sum >> WEIGHT_FRAC_BITS);
      end
   end

   // encode: one code bit per stage, MSB first, keep it if its decode fits
   for (genvar j = 0; j < ENC_STAGES; j++) begin : g_enc
      logic [CODE_W-1:0] code_prev [NUM_CHAN];
      logic [LIN_W-1:0]  lin_prev  [NUM_CHAN];
      logic [CODE_W-1:0] alpha_prev;
      logic [CODE_W-1:0] cand      [NUM_CHAN];

      if (j == 0) begin : g_head
         always_comb begin
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
               code_prev[ch] = '0;
               lin_prev[ch]  = mix_ff[ch];
            end
            alpha_prev = amix_ff;
         end
      end else begin : g_body
         always_comb begin
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
               code_prev[ch] = code_ff[j-1][ch];
               lin_prev[ch]  = vlin_ff[j-1][ch];
            end
            alpha_prev = alpha_ff[j-1];
         end
      end

      always_comb begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            cand[ch] = code_prev[ch] | (CODE_W'(1) << (CODE_W - 1 - j));
            if (DecTable[cand[ch]][LIN_W-1:0] <= lin_prev[ch]) begin
               code_in[j][ch] = cand[ch];
            end else begin
               code_in[j][ch] = code_prev[ch];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance[ENC_FIRST+j]) begin
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
               code_ff[j][ch] <= code_in[j][ch];
               vlin_ff[j][ch] <= lin_prev[ch];
            end
            alpha_ff[j] <= alpha_prev;
         end
      end
   end

   // response beat: R G B A, red in the top byte
   assign rsp_tdata = {code_ff[ENC_STAGES-1][0], code_ff[ENC_STAGES-1][1],
                       code_ff[ENC_STAGES-1][2], alpha_ff[ENC_STAGES-1]};

endmodule

### tb/tb_gamma_correct_color_blend_top.sv
// ============================================================================
// tb_gamma_correct_color_blend_top - stream testbench for the colour blender
// Drives pixel beats (two RGBA colours and a blend weight) into the pipeline
// with random gaps, and back-pressures the response side at random. Results
// are predicted from an independently built sRGB decode table and compared
// beat by beat, in order.
// ============================================================================
module tb_gamma_correct_color_blend_top;
   import gcb_pkg::*;

   localparam int          LIN_BITS      = LINEAR_FRAC_BITS_DEF;
   localparam int          WGT_BITS      = WEIGHT_FRAC_BITS_DEF;
   localparam longint      WGT_ONE       = longint'(1) << WGT_BITS;
   localparam longint      Q30_ONE       = longint'(1) << 30;
   // linear segment: c / 255 / 12.92 with round-half-up
   localparam longint      SEG_DIV       = 329460;
   localparam longint      SEG_HALF      = 164730;
   localparam int          SEG_LAST_CODE = 10;
   // power segment: (c/255 + 0.055) / 1.055 scaled by 1000
   localparam longint      PWR_OFFSET    = 14025;
   localparam longint      PWR_DIV       = 269025;
   localparam int          IDLE_LIMIT    = 4000;
   localparam int          LONG_STALL    = 80;
   localparam int          DRAIN_CYCLES  = 30;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stream signals; those the bench drives are known from time zero
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // first_color[31:0], second_color[63:32], blend_weight[80:64], zero pad
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // blended_color[31:0]
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   gamma_correct_color_blend_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // predictor state and scoreboard
   longint unsigned  lin_of_code [NUM_CODES];
   logic [31:0]      pending_blends [$];
   int               pixels_sent       = 0;
   int               saturated_weights = 0;
   int               blends_checked    = 0;
   int               mismatch_count    = 0;
   int               long_hold         = 0;
   bit               req_gaps_on       = 1'b1;
   bit               rsp_gaps_on       = 1'b1;

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // r^5 in Q0.30, truncated after every product
   function automatic longint unsigned q30_fifth_power(longint unsigned r);
      longint unsigned acc;
      acc = r;
      repeat (4) acc = (acc * r) >> 30;
      return acc;
   endfunction

   // sRGB code to linear light, Q0.LIN_BITS
   function automatic longint unsigned srgb_code_to_linear(int code);
      longint unsigned cv;
      longint unsigned x;
      longint unsigned x_sq;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned probe;
      longint unsigned x_pow;
      cv = longint'(code);
      if (code <= SEG_LAST_CODE) begin
         return ((cv * 100 << LIN_BITS) + SEG_HALF) / SEG_DIV;
      end
      x    = ((1000 * cv + PWR_OFFSET) << 30) / PWR_DIV;
      x_sq = (x * x) >> 30;
      // x^0.4 as the largest fifth root not above x^2
      lo = 0;
      hi = Q30_ONE;
      while (lo < hi) begin
         probe = (lo + hi + 1) >> 1;
         if (q30_fifth_power(probe) <= x_sq) begin
            lo = probe;
         end else begin
            hi = probe - 1;
         end
      end
      x_pow = (x_sq * lo) >> 30;
      return (x_pow + (longint'(1) << (29 - LIN_BITS))) >> (30 - LIN_BITS);
   endfunction

   // largest code whose linear value does not exceed v
   function automatic logic [7:0] linear_to_srgb_code(longint unsigned v);
      for (int k = NUM_CODES - 1; k > 0; k--) begin
         if (lin_of_code[k] <= v) return 8'(k);
      end
      return 8'd0;
   endfunction

   function automatic longint unsigned lerp_weight(longint unsigned a, longint unsigned b,
                                                   longint unsigned w);
      return (a * (WGT_ONE - w) + b * w) >> WGT_BITS;
   endfunction

   function automatic logic [31:0] predict_blend(logic [31:0] c1, logic [31:0] c2,
                                                 logic [16:0] weight);
      longint unsigned w;
      logic [31:0]     px;
      w  = (longint'(weight) > WGT_ONE) ? WGT_ONE : longint'(weight);
      px = '0;
      // R, G, B through linear light; alpha straight on the codes
      for (int sh = 24; sh >= 8; sh -= 8) begin
         px[sh +: 8] = linear_to_srgb_code(lerp_weight(lin_of_code[c1[sh +: 8]],
                                                       lin_of_code[c2[sh +: 8]], w));
      end
      px[7:0] = 8'(lerp_weight(longint'(c1[7:0]), longint'(c2[7:0]), w));
      return px;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // mostly short gaps, now and then a long one
   function automatic int pick_gap_len();
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] random_colour();
      logic [31:0] c;
      int          r;
      for (int b = 0; b < 4; b++) begin
         r = $urandom_range(0, 99);
         if (r < 60)      c[8*b +: 8] = 8'($urandom_range(0, 255));
         else if (r < 80) c[8*b +: 8] = 8'($urandom_range(0, 15));
         else if (r < 90) c[8*b +: 8] = 8'hFF;
         else             c[8*b +: 8] = 8'h00;
      end
      return c;
   endfunction

   function automatic logic [16:0] random_weight();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 17'($urandom_range(0, WGT_ONE));
      if (r < 80) begin
         case ($urandom_range(0, 4))
            0:       return 17'd0;
            1:       return 17'd1;
            2:       return 17'(WGT_ONE - 1);
            3:       return 17'(WGT_ONE / 2);
            default: return 17'(WGT_ONE);
         endcase
      end
      if (r < 90) return 17'($urandom_range(0, 131071));
      return 17'($urandom_range(0, 255));
   endfunction

   // offer one pixel beat, hold it until taken, then queue its blend
   task automatic send_pixel(input logic [31:0] c1, input logic [31:0] c2,
                             input logic [16:0] weight);
      int gap;
      gap = 0;
      if (req_gaps_on && $urandom_range(0, 99) < 25) gap = pick_gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({weight, c2, c1});
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_blends.push_back(predict_blend(c1, c2, weight));
      pixels_sent++;
      if (longint'(weight) > WGT_ONE) saturated_weights++;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   task automatic test_extreme_values();
      send_pixel(32'h0000_0000, 32'h0000_0000, 17'd0);
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'(WGT_ONE));
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 17'd0);
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 17'(WGT_ONE / 2));
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 17'(WGT_ONE));
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 17'd1);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 17'(WGT_ONE - 1));
      send_pixel(32'hFF00_FF00, 32'h00FF_00FF, 17'(WGT_ONE / 4));
   endtask

   // weights above one must act as one
   task automatic test_weight_saturation();
      send_pixel(32'h1234_5678, 32'h9ABC_DEF0, 17'(WGT_ONE + 1));
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 17'h1FFFF);
      send_pixel(32'h0000_0000, 32'h8040_20FF, 17'h18000);
      send_pixel(random_colour(), random_colour(), 17'h1_5555);
      send_pixel(random_colour(), random_colour(), 17'h1_AAAA);
   endtask

   // identical colours come back unchanged whatever the weight
   task automatic test_equal_colours();
      logic [31:0] c;
      send_pixel(32'h0A0B_0C0D, 32'h0A0B_0C0D, 17'(WGT_ONE / 3));
      send_pixel(32'h8080_8080, 32'h8080_8080, 17'd12345);
      for (int i = 0; i < 4; i++) begin
         c = $urandom();
         send_pixel(c, c, random_weight());
      end
   endtask

   // codes either side of the bend between linear and power segments
   task automatic test_linear_segment();
      send_pixel(32'h0001_0203, 32'h0A0B_0C0D, 17'(WGT_ONE / 2));
      send_pixel(32'h0405_0607, 32'h0809_0A0B, 17'(WGT_ONE / 3));
      send_pixel(32'h0000_0000, 32'h0B0B_0B0B, 17'd40000);
      send_pixel(32'h0A0A_0A0A, 32'h0C0C_0C0C, 17'd20000);
   endtask

   task automatic test_random_blends(input int count);
      logic [31:0] c1;
      logic [31:0] c2;
      for (int i = 0; i < count; i++) begin
         // alternate stretches with and without idling
         if (i % 100 == 0) begin
            req_gaps_on = ((i / 100) % 3) != 2;
            rsp_gaps_on = ((i / 100) % 4) != 3;
         end
         c1 = random_colour();
         c2 = ($urandom_range(0, 9) == 0) ? c1 : random_colour();
         send_pixel(c1, c2, random_weight());
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // hold the output off long enough that the pipeline fills and stalls input
   task automatic test_output_backpressure(input int count);
      req_gaps_on = 1'b0;
      long_hold   = LONG_STALL;
      for (int i = 0; i < count; i++) begin
         send_pixel(random_colour(), random_colour(), random_weight());
      end
      req_gaps_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      for (int c = 0; c < NUM_CODES; c++) lin_of_code[c] = srgb_code_to_linear(c);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_values();
      test_weight_saturation();
      test_equal_colours();
      test_linear_segment();
      test_random_blends(820);
      test_output_backpressure(60);

      req_tvalid <= 1'b0;
      while (pending_blends.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Blended %0d pixels (%0d with saturating weight), %0d responses checked,",
               pixels_sent, saturated_weights, blends_checked);
      $display("under random gaps, random output stalls and one long output stall.");
      if (mismatch_count == 0 && pending_blends.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // response side: ready generation and in-order checking
   // ------------------------------------------------------------------------
   initial begin : response_side
      int          rsp_hold;
      logic [31:0] want;
      rsp_hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (pending_blends.size() == 0) begin
               $error("blended_color: no beat expected, got %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = pending_blends.pop_front();
               blends_checked++;
               if (rsp_tdata !== want) begin
                  $error("blended_color: expected %h, got %h", want, rsp_tdata);
                  mismatch_count++;
               end
            end
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_tready <= 1'b0;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 99) < 20) begin
            rsp_hold = pick_gap_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: too long without any beat moving on either side
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

endmodule

### sim.f
src/gcb_pkg.sv
src/gamma_correct_color_blend_top.sv
tb/tb_gamma_correct_color_blend_top.sv
